[hdl/tlbat_pkg.sv]
// Package for the address translation buffer: entry layouts, action and
// fault codes, and the size of the entry store.
// It depends on nothing; tlb_address_translate imports it.
package tlbat_pkg;

    // Number of entries in the fully associative store.
    localparam int ENTRIES = 16;

    // Widths fixed by the item fields.
    localparam int VPN2_W  = 19;
    localparam int ASID_W  = 8;
    localparam int FRAME_W = 20;
    localparam int INDEX_W = 4;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 32;

    // Action codes carried in s_tuser.
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_STORE  = 2'd1;
    localparam logic [1:0] ACT_WRITE  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Fault codes carried in m_tuser.
    localparam logic [2:0] FAULT_NONE       = 3'd0;
    localparam logic [2:0] FAULT_LOAD_MISS  = 3'd1;
    localparam logic [2:0] FAULT_STORE_MISS = 3'd2;
    localparam logic [2:0] FAULT_LOAD_INV   = 3'd3;
    localparam logic [2:0] FAULT_STORE_INV  = 3'd4;
    localparam logic [2:0] FAULT_MOD        = 3'd5;

    // Tag half of an entry.
    typedef struct packed {
        logic [VPN2_W-1:0] vpn2;
        logic [ASID_W-1:0] asid;
        logic              global_flag;
    } tag_t;

    // One page of an entry.
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               valid;
        logic               dirty;
    } page_t;

endpackage

[hdl/tlb_address_translate.sv]
// Address translation buffer: fully associative store of paired 4 KiB pages
// with an input register, one lookup pass and a result register.
// Depends on tlbat_pkg for entry types, codes and the store size.
//
// Channel   Direction  Handshake          Contents
// s_        in         s_tvalid/s_tready  action in tuser, entry and address in tdata
// m_        out        m_tvalid/m_tready  phys_addr in tdata, fault in tuser
// cfg_      in         cfg_we             current address space id
//
// An item is taken every cycle while s_tready is high. A lookup result passes the input
// register, the single compare-and-select pass over all entries and then the result
// register; a stall on the result side can hold it in the input register.
// Entry writes and unused actions pass the input register and give no result.
// Reset clears the whole entry store and the current address space id at once.
// A stalled result holds the result register and, once the input register is
// also full, s_tready falls.
module tlb_address_translate
    import tlbat_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // From bit 0: entry_index(4), address(32), entry_asid(8), entry_global(1),
    // even_frame(20), even_valid(1), even_dirty(1), odd_frame(20),
    // odd_valid(1), odd_dirty(1), zero fill(7).
    input  logic [IN_W-1:0]  s_tdata,
    // From bit 0: action(2).
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // From bit 0: phys_addr(32).
    output logic [OUT_W-1:0] m_tdata,
    // From bit 0: fault(3).
    output logic [2:0]       m_tuser,
    input  logic             cfg_we,
    input  logic [ASID_W-1:0] cfg_wdata
);

    // Configuration register.
    logic [ASID_W-1:0] asid_reg;

    // Entry store.
    tag_t  tag_reg  [ENTRIES];
    page_t even_reg [ENTRIES];
    page_t odd_reg  [ENTRIES];

    // Input register.
    logic              s1_valid_reg;
    logic [1:0]        s1_action_reg;
    logic [IN_W-1:0]   s1_data_reg;

    // Result register.
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_addr_reg;
    logic [2:0]        m_fault_reg;

    // Fields of the held item.
    logic [INDEX_W-1:0] s1_index;
    logic [31:0]        s1_address;
    tag_t               s1_tag;
    page_t              s1_even;
    page_t              s1_odd;

    logic s1_lookup;
    logic s1_adv;
    logic out_load;
    logic store_write;

    // Lookup pass.
    logic [ENTRIES-1:0] match_vec;
    logic               hit;
    page_t              sel_page;
    logic [2:0]         fault_next;
    logic [OUT_W-1:0]   addr_next;

    assign s1_index   = s1_data_reg[3:0];
    assign s1_address = s1_data_reg[35:4];
    assign s1_tag     = {s1_data_reg[35:17], s1_data_reg[43:36], s1_data_reg[44]};
    assign s1_even    = {s1_data_reg[64:45], s1_data_reg[65], s1_data_reg[66]};
    assign s1_odd     = {s1_data_reg[86:67], s1_data_reg[87], s1_data_reg[88]};

    // Flow control: a lookup moves on only when the result register is empty or being taken.
    assign s1_lookup   = (s1_action_reg == ACT_LOAD) || (s1_action_reg == ACT_STORE);
    assign s1_adv      = s1_valid_reg && (!s1_lookup || !m_valid_reg || m_tready);
    assign out_load    = s1_adv && s1_lookup;
    assign store_write = s1_adv && (s1_action_reg == ACT_WRITE)
                         && (int'(s1_index) < ENTRIES);
    assign s_tready    = !s1_valid_reg || s1_adv;

    // Compare every entry; the lowest-indexed match selects the page.
    always_comb begin
        hit      = 1'b0;
        sel_page = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = (tag_reg[i].vpn2 == s1_address[31:13])
                           && (tag_reg[i].global_flag || (tag_reg[i].asid == asid_reg));
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                hit      = 1'b1;
                sel_page = s1_address[12] ? odd_reg[i] : even_reg[i];
            end
        end
    end

    // Fault classification and physical address.
    always_comb begin
        addr_next = '0;
        priority if (!hit) begin
            fault_next = (s1_action_reg == ACT_STORE) ? FAULT_STORE_MISS : FAULT_LOAD_MISS;
        end else if (!sel_page.valid) begin
            fault_next = (s1_action_reg == ACT_STORE) ? FAULT_STORE_INV : FAULT_LOAD_INV;
        end else if (!sel_page.dirty && (s1_action_reg == ACT_STORE)) begin
            fault_next = FAULT_MOD;
        end else begin
            fault_next = FAULT_NONE;
            addr_next  = {sel_page.frame, s1_address[11:0]};
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asid_reg <= '0;
        end else if (cfg_we) begin
            asid_reg <= cfg_wdata;
        end
    end

    // Entry store: cleared by reset, one slot written per write item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tag_reg[i]  <= '0;
                even_reg[i] <= '0;
                odd_reg[i]  <= '0;
            end
        end else if (store_write) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (int'(s1_index) == i) begin
                    tag_reg[i]  <= s1_tag;
                    even_reg[i] <= s1_even;
                    odd_reg[i]  <= s1_odd;
                end
            end
        end
    end

    // Input register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_action_reg <= s_tuser;
            s1_data_reg   <= s_tdata;
        end
    end

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_addr_reg  <= addr_next;
            m_fault_reg <= fault_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_fault_reg;

    // A result never carries a code beyond the modification fault.
    a_fault_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_fault_reg <= FAULT_MOD))
        else $error("fault code out of range");

    // An item that gives no result never raises the result valid.
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && !s1_lookup) |=> !$rose(m_valid_reg))
        else $error("result raised by a write or unused action");

    // A store lookup yields only store-class faults or success.
    a_store_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (s1_action_reg == ACT_STORE)) |=>
        ((m_fault_reg == FAULT_NONE) || (m_fault_reg == FAULT_STORE_MISS)
         || (m_fault_reg == FAULT_STORE_INV) || (m_fault_reg == FAULT_MOD)))
        else $error("store lookup with load-class fault");

    // A held item that cannot move keeps its action.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_action_reg)))
        else $error("stalled item lost");

endmodule

[dv/tb_tlb_address_translate.sv]
// Self-checking testbench for tlb_address_translate: directed and random lookups,
// entry writes and address space changes, with random idling on both channels.
// Depends on tlbat_pkg and hdl/tlb_address_translate.sv.
module tb_tlb_address_translate;
    import tlbat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF         = 2;
    localparam int PIPE_DEPTH       = 2;
    localparam int IDLE_LIMIT       = 2000;
    localparam int RANDOM_PER_PHASE = 235;
    localparam int PAIR_POOL        = 8;
    localparam int REPORT_LIMIT     = 10;

    // One input item, fields as the block sees them.
    typedef struct packed {
        logic [1:0]         action;
        logic [INDEX_W-1:0] slot;
        logic [31:0]        address;
        logic [ASID_W-1:0]  asid;
        logic               global_flag;
        page_t              even_page;
        page_t              odd_page;
    } tlb_item_t;

    // One translation result.
    typedef struct packed {
        logic [31:0] phys_addr;
        logic [2:0]  fault;
    } translation_t;

    // Mirror of the entry store that predicts every lookup and checks the results.
    class translation_predictor;
        tag_t              tags[ENTRIES];
        page_t             even_pages[ENTRIES];
        page_t             odd_pages[ENTRIES];
        logic [ASID_W-1:0] running_asid;
        translation_t      pending_translations[$];
        int                fail_count;

        function new();
            running_asid = '0;
            fail_count   = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                tags[i]       = '0;
                even_pages[i] = '0;
                odd_pages[i]  = '0;
            end
        endfunction

        function void set_asid(logic [ASID_W-1:0] value);
            running_asid = value;
        endfunction

        function int pending_count();
            return pending_translations.size();
        endfunction

        // Applies an accepted item: writes fill an entry, lookups queue a translation.
        function void accept_item(tlb_item_t it);
            translation_t res;
            page_t        pg;
            logic         hit;
            logic         is_store;
            if (it.action == ACT_WRITE) begin
                if (it.slot < ENTRIES) begin
                    tags[it.slot].vpn2        = it.address[31:13];
                    tags[it.slot].asid        = it.asid;
                    tags[it.slot].global_flag = it.global_flag;
                    even_pages[it.slot]       = it.even_page;
                    odd_pages[it.slot]        = it.odd_page;
                end
                return;
            end
            if (it.action == ACT_UNUSED)
                return;
            is_store      = (it.action == ACT_STORE);
            hit           = 1'b0;
            res.phys_addr = '0;
            res.fault     = is_store ? FAULT_STORE_MISS : FAULT_LOAD_MISS;
            // The lowest-indexed matching entry decides; bit 12 picks the half.
            for (int i = 0; i < ENTRIES; i++) begin
                if (!hit && tags[i].vpn2 == it.address[31:13] &&
                        (tags[i].global_flag || tags[i].asid == running_asid)) begin
                    hit = 1'b1;
                    pg  = it.address[12] ? odd_pages[i] : even_pages[i];
                    if (!pg.valid) begin
                        res.fault = is_store ? FAULT_STORE_INV : FAULT_LOAD_INV;
                    end else if (!pg.dirty && is_store) begin
                        res.fault = FAULT_MOD;
                    end else begin
                        res.fault     = FAULT_NONE;
                        res.phys_addr = {pg.frame, it.address[11:0]};
                    end
                end
            end
            pending_translations.push_back(res);
        endfunction

        // Compares a result from the block with the oldest translation waiting.
        function void check_translation(logic [31:0] phys_addr, logic [2:0] fault);
            translation_t want;
            if (pending_translations.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing expected: phys_addr %h fault %0d",
                             $realtime, phys_addr, fault);
                return;
            end
            want = pending_translations.pop_front();
            if (phys_addr !== want.phys_addr || fault !== want.fault) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: mismatch: phys_addr %h (expected %h) fault %0d (expected %0d)",
                             $realtime, phys_addr, want.phys_addr, fault, want.fault);
            end
        endfunction
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic [1:0]        s_tuser   = ACT_LOAD;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [2:0]        m_tuser;
    logic              cfg_we    = 1'b0;
    logic [ASID_W-1:0] cfg_wdata = '0;

    translation_predictor predictor;
    logic [VPN2_W-1:0]    pair_pool[PAIR_POOL];
    logic                 quiet_stretch = 1'b0;
    int                   idle_cycles   = 0;

    tlb_address_translate u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Now and then switch between random idling and back-to-back stretches.
    always @(posedge aclk) begin
        if ($urandom_range(0, 99) == 0)
            quiet_stretch <= ~quiet_stretch;
    end

    // Watchdog: ends the run when nothing has been accepted for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int draw_gap();
        return quiet_stretch ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic page_t make_page(logic [FRAME_W-1:0] frame, logic valid, logic dirty);
        page_t pg;
        pg.frame = frame;
        pg.valid = valid;
        pg.dirty = dirty;
        return pg;
    endfunction

    function automatic tlb_item_t make_lookup(logic [1:0] action, logic [31:0] address);
        tlb_item_t it;
        it         = '0;
        it.action  = action;
        it.address = address;
        return it;
    endfunction

    function automatic tlb_item_t make_write(logic [INDEX_W-1:0] slot, logic [31:0] address,
                                             logic [ASID_W-1:0] asid, logic global_flag,
                                             page_t even_page, page_t odd_page);
        tlb_item_t it;
        it.action      = ACT_WRITE;
        it.slot        = slot;
        it.address     = address;
        it.asid        = asid;
        it.global_flag = global_flag;
        it.even_page   = even_page;
        it.odd_page    = odd_page;
        return it;
    endfunction

    // Mostly writes and lookups on a small set of page pairs, so that entries
    // are hit, shadowed and overwritten; a few unused actions as noise.
    function automatic tlb_item_t random_item(logic [ASID_W-1:0] cur_asid);
        tlb_item_t it;
        int        roll;
        int        pick;
        roll           = $urandom_range(0, 99);
        it.slot        = INDEX_W'($urandom_range(0, ENTRIES - 1));
        it.address     = $urandom();
        it.asid        = ASID_W'($urandom_range(0, 255));
        it.global_flag = ($urandom_range(0, 3) == 0);
        it.even_page   = make_page(FRAME_W'($urandom_range(0, 20'hfffff)),
                                   $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
        it.odd_page    = make_page(FRAME_W'($urandom_range(0, 20'hfffff)),
                                   $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
        if (roll < 4) begin
            it.action = ACT_UNUSED;
        end else begin
            if ($urandom_range(0, 9) != 0)
                it.address[31:13] = pair_pool[3'($urandom_range(0, PAIR_POOL - 1))];
            if (roll < 30) begin
                it.action = ACT_WRITE;
                pick      = $urandom_range(0, 9);
                if (pick < 5)
                    it.asid = cur_asid;
                else if (pick < 7)
                    it.asid = cur_asid ^ 8'h01;
            end else begin
                it.action = $urandom_range(0, 1) ? ACT_STORE : ACT_LOAD;
            end
        end
        return it;
    endfunction

    // Presents one item after a random gap and waits until it is taken.
    task automatic send_item(input tlb_item_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {7'd0,
                     it.odd_page.dirty, it.odd_page.valid, it.odd_page.frame,
                     it.even_page.dirty, it.even_page.valid, it.even_page.frame,
                     it.global_flag, it.asid, it.address, it.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predictor.accept_item(it);
    endtask

    // Changes the address space id once the block has drained.
    task automatic set_running_asid(input logic [ASID_W-1:0] value);
        s_tvalid <= 1'b0;
        while (predictor.pending_count() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        predictor.set_asid(value);
    endtask

    // Result side: random stall before each item, then check what arrives.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            predictor.check_translation(m_tdata, m_tuser);
        end
    end

    // Stimulus and end of run.
    initial begin
        tlb_item_t         it;
        int                sent;
        logic [ASID_W-1:0] phase_asid;
        predictor = new();
        pair_pool[0] = '0;
        pair_pool[1] = '1;
        for (int i = 2; i < PAIR_POOL; i++)
            pair_pool[i] = VPN2_W'($urandom_range(0, 19'h7ffff));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset entries are real: page pair 0 in space 0 hits with invalid pages.
        send_item(make_lookup(ACT_LOAD, 32'h0000_0000));
        send_item(make_lookup(ACT_STORE, 32'h0000_1fff));
        // Misses on both actions.
        send_item(make_lookup(ACT_LOAD, 32'hffff_ffff));
        send_item(make_lookup(ACT_STORE, 32'h0000_2000));
        // Unused action with every field bit set must leave no trace.
        it        = '1;
        it.action = ACT_UNUSED;
        send_item(it);
        // Top page pair twice: private to space 255 in slot 0, global in slot 15.
        send_item(make_write(4'd0, 32'hffff_ffff, 8'hff, 1'b0,
                             make_page(20'hfffff, 1'b1, 1'b1), make_page(20'h00000, 1'b1, 1'b0)));
        send_item(make_write(4'd15, 32'hffff_e000, 8'h00, 1'b1,
                             make_page(20'h12345, 1'b1, 1'b1), make_page(20'habcde, 1'b0, 1'b1)));
        send_item(make_lookup(ACT_LOAD, 32'hffff_efff));
        send_item(make_lookup(ACT_STORE, 32'hffff_f000));
        send_item(make_lookup(ACT_STORE, 32'hffff_e000));
        // Page pair 0 in slot 1 shadows the reset entries behind it; even half is clean.
        send_item(make_write(4'd1, 32'h0000_0000, 8'h00, 1'b0,
                             make_page(20'h0000f, 1'b1, 1'b0), make_page(20'h54321, 1'b1, 1'b1)));
        send_item(make_lookup(ACT_STORE, 32'h0000_0123));
        send_item(make_lookup(ACT_LOAD, 32'h0000_0123));
        send_item(make_lookup(ACT_STORE, 32'h0000_1abc));

        // Highest address space: slot 0 now wins over the global slot 15.
        set_running_asid(8'hff);
        send_item(make_lookup(ACT_LOAD, 32'hffff_efff));
        send_item(make_lookup(ACT_STORE, 32'hffff_f001));
        send_item(make_lookup(ACT_LOAD, 32'hffff_f001));
        send_item(make_lookup(ACT_LOAD, 32'h0000_0000));
        send_item(make_lookup(ACT_STORE, 32'h0000_1fff));

        // Random phases, each under its own address space id, extremes included.
        for (int p = 0; p < 4; p++) begin
            if (p == 0)
                phase_asid = 8'h00;
            else if (p == 2)
                phase_asid = 8'hff;
            else
                phase_asid = ASID_W'($urandom_range(1, 254));
            set_running_asid(phase_asid);
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                it = random_item(phase_asid);
                send_item(it);
                if (it.action != ACT_UNUSED)
                    sent++;
            end
        end

        // Drain, then allow the pipeline to settle.
        s_tvalid <= 1'b0;
        while (predictor.pending_count() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
        if (predictor.fail_count == 0 && predictor.pending_count() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
